// ----- hw/rtl/sitad_pkg.sv -----
package sitad_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // Controls from the sequencer to the digit shifter
  typedef struct packed {
    logic load;       // take a new magnitude, clear digits
    logic dabble;     // one binary bit into the digit register
    logic nib_shift;  // drop the top digit
  } conv_ctrl_t;

  // Controls from the sequencer to the output stage
  typedef struct packed {
    logic push;       // write a character into the output register
    logic sel_sign;   // character is the minus sign
    logic last;       // final character of the text
  } emit_ctrl_t;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ALPHA = 8'h57;  // 'a' - 10
  localparam logic [3:0] DEC_LIMIT  = 4'd10;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < DEC_LIMIT) begin
      r = CHAR_ZERO + {4'h0, d};
    end else begin
      r = CHAR_ALPHA + {4'h0, d};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sitad_conv.sv -----
module sitad_conv #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS     = 10
) (
  input  logic                   clk,
  input  sitad_pkg::conv_ctrl_t  ctrl,
  input  logic [VALUE_BITS-1:0]  mag_in,
  input  logic                   hex,
  output logic [3:0]             top_digit
);
  import sitad_pkg::*;

  localparam int DIG_BITS = DIGITS * 4;

  logic [VALUE_BITS-1:0] mag;
  logic [DIG_BITS-1:0]   digits;
  logic [DIG_BITS-1:0]   adj;
  logic                  hex_q;

  // shift-add-3 correction, skipped in hex mode (plain binary shift)
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (!hex_q && digits[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = digits[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = digits[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag    <= mag_in;
      digits <= '0;
      hex_q  <= hex;
    end else if (ctrl.dabble) begin
      mag    <= {mag[VALUE_BITS-2:0], 1'b0};
      digits <= {adj[DIG_BITS-2:0], mag[VALUE_BITS-1]};
    end else if (ctrl.nib_shift) begin
      digits <= {digits[DIG_BITS-5:0], 4'h0};
    end
  end

  assign top_digit = digits[DIG_BITS-1 -: 4];

endmodule

// ----- hw/rtl/sitad_emit.sv -----
module sitad_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  sitad_pkg::emit_ctrl_t  ctrl,
  input  logic [3:0]             digit,
  output logic                   free,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast
);
  import sitad_pkg::*;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      m_tdata <= ctrl.sel_sign ? CHAR_MINUS : digit_char(digit);
      m_tlast <= ctrl.last;
    end
  end

endmodule

// ----- hw/rtl/signed_int_to_ascii_digits.sv -----
// Signed integer to ASCII text, decimal or lowercase hex.
//
// Input stream (s_*): one transfer carries a two's complement value and a
// radix bit. Output stream (m_*): one transfer per character, most
// significant first; a negative value starts with '-' and then the digits
// of its magnitude (hex too). Zero gives "0". tlast marks the final char.
//
// Per value: a load, bit-serial conversion of all VALUE_BITS bits
// (shift-add-3 for decimal, plain binary shift for hex), then one pass
// over all DIGITS nibbles: one leading zero dropped per cycle, a step to
// leave the skip, the '-' for a negative value, then one character per
// cycle while the receiver keeps up. One value is in work at a time;
// s_tready is high only while idle. The output register lets the next
// value be taken while the last character still waits. A stalled
// receiver halts emission; nothing is dropped. Reset (rst, synchronous)
// returns to idle and empties the output register.
module signed_int_to_ascii_digits #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // fields from bit 0: value[VALUE_BITS-1:0], mode, zero fill
  input  logic [((VALUE_BITS+8)/8)*8-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // fields from bit 0: out_char[7:0]
  output logic [7:0]                      m_tdata,
  output logic                            m_tlast
);
  import sitad_pkg::*;

  // digit register holds enough nibbles for either radix
  localparam int NDEC   = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int NHEX   = (VALUE_BITS + 3) / 4;
  localparam int DIGITS = (NDEC > NHEX) ? NDEC : NHEX;
  localparam int BW     = $clog2(VALUE_BITS);
  localparam int RW     = $clog2(DIGITS + 1);
  localparam logic [BW-1:0] BIT_LAST = BW'(VALUE_BITS - 1);
  localparam logic [RW-1:0] REM_FULL = RW'(DIGITS);
  localparam logic [RW-1:0] REM_ONE  = RW'(1);

  state_t state, state_next;
  logic [BW-1:0] bit_cnt;
  logic [RW-1:0] rem;
  logic          neg_q;

  logic [VALUE_BITS-1:0] value;
  logic                  mode;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [3:0]            top_digit;
  logic                  free;
  logic                  lead_zero;
  conv_ctrl_t            conv_ctrl;
  emit_ctrl_t            emit_ctrl;

  assign value = s_tdata[VALUE_BITS-1:0];
  assign mode  = s_tdata[VALUE_BITS];
  assign neg   = value[VALUE_BITS-1];
  // unsigned magnitude, so the most negative value converts as well
  assign mag   = neg ? (~value + VALUE_BITS'(1)) : value;

  // a leading zero is dropped unless it is the only digit left
  assign lead_zero = (top_digit == 4'h0) && (rem > REM_ONE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_CONV;
      ST_CONV:  if (bit_cnt == BIT_LAST) state_next = ST_SKIP;
      ST_SKIP:  if (!lead_zero) state_next = neg_q ? ST_SIGN : ST_DIGIT;
      ST_SIGN:  if (free) state_next = ST_DIGIT;
      ST_DIGIT: if (free && rem == REM_ONE) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready            = 1'b0;
    conv_ctrl           = '0;
    emit_ctrl           = '0;
    case (state)
      ST_IDLE: begin
        s_tready       = 1'b1;
        conv_ctrl.load = s_tvalid;
      end
      ST_CONV: begin
        conv_ctrl.dabble = 1'b1;
      end
      ST_SKIP: begin
        conv_ctrl.nib_shift = lead_zero;
      end
      ST_SIGN: begin
        emit_ctrl.push     = free;
        emit_ctrl.sel_sign = 1'b1;
      end
      ST_DIGIT: begin
        emit_ctrl.push      = free;
        emit_ctrl.last      = (rem == REM_ONE);
        conv_ctrl.nib_shift = free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // step and digit counters
  always_ff @(posedge clk) begin
    if (conv_ctrl.load) begin
      bit_cnt <= '0;
      rem     <= REM_FULL;
      neg_q   <= neg;
    end else begin
      if (conv_ctrl.dabble) begin
        bit_cnt <= bit_cnt + BW'(1);
      end
      if (conv_ctrl.nib_shift) begin
        rem <= rem - REM_ONE;
      end
    end
  end

  sitad_conv #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_conv (
    .clk       (clk),
    .ctrl      (conv_ctrl),
    .mag_in    (mag),
    .hex       (mode),
    .top_digit (top_digit)
  );

  sitad_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (emit_ctrl),
    .digit    (top_digit),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- tb/tb.sv -----
module tb;
  import sitad_pkg::*;

  // radix select on the mode bit
  localparam logic RADIX_DEC = 1'b0;
  localparam logic RADIX_HEX = 1'b1;

  localparam int          VALUE_W      = 32;
  localparam int          FILL_W       = 7;
  localparam int          TDATA_W      = VALUE_W + 1 + FILL_W;
  localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
  localparam int          HOLD_CYCLES  = 240;   // long receiver hold-off
  localparam int          STALL_LIMIT  = 2000;  // quiet cycles before giving up
  localparam int          DRAIN_CYCLES = 60;    // about one conversion

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } text_char_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // fields from bit 0: value[31:0], mode, zero fill[6:0]
  logic [TDATA_W-1:0] s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // fields from bit 0: out_char[7:0]
  logic [7:0]         m_tdata;
  logic               m_tlast;

  // characters still owed by the block, oldest first
  text_char_t pending_text[$];

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs     = 0;   // bumped by a test to ask for a long hold-off
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  signed_int_to_ascii_digits #(.VALUE_BITS(VALUE_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // Predicted text of one accepted value: optional '-', then the digits of
  // the magnitude, most significant first. The magnitude is the unsigned
  // 32-bit negation, so the most negative value comes out right.
  task automatic queue_text(input logic [VALUE_W-1:0] v, input logic radix);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         dig;
    logic [7:0]         rev [0:15];
    int                 nd;
    text_char_t         c;
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    nd  = 0;
    do begin
      if (radix == RADIX_HEX) begin
        dig = mag[3:0];
        mag = mag >> 4;
      end else begin
        dig = 4'(mag % 10);
        mag = mag / 10;
      end
      rev[nd] = (dig < 4'd10) ? CHAR_ZERO + 8'(dig) : CHAR_LOWER_A + 8'(dig) - 8'd10;
      nd++;
    end while (mag != 0);
    if (v[VALUE_W-1]) begin
      c.ch      = CHAR_MINUS;
      c.is_last = 1'b0;
      pending_text.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.ch      = rev[k];
      c.is_last = (k == 0);
      pending_text.push_back(c);
    end
  endtask

  // One input transfer. Valid stays high from the previous item when no
  // gap is drawn, so back-to-back items never drop valid in between.
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic radix,
                            input logic [FILL_W-1:0] fill);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= TDATA_W'({$urandom, $urandom});  // junk while idle
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {fill, radix, v};
    do @(posedge clk); while (!s_tready);
    queue_text(v, radix);
  endtask

  // Mix of full-range words, small numbers, decade boundaries and extremes.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    p = 1;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 20);
      2: v = -$urandom_range(1, 20);
      3: begin
        for (int i = $urandom_range(0, 9); i > 0; i--) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'hffff_ffff;
          default: v = 32'h8000_0001;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // --- tests -------------------------------------------------------------

  // extremes, both radices, digit-count edges, stray fill bits
  task automatic test_directed();
    send_value(32'd0,          RADIX_DEC, '0);
    send_value(32'd0,          RADIX_HEX, '0);
    send_value(32'd1,          RADIX_DEC, '0);
    send_value(32'hffff_ffff,  RADIX_DEC, '0);   // -1
    send_value(32'hffff_ffff,  RADIX_HEX, '0);
    send_value(32'h7fff_ffff,  RADIX_DEC, '0);
    send_value(32'h7fff_ffff,  RADIX_HEX, '0);
    send_value(32'h8000_0000,  RADIX_DEC, '0);   // longest text, 11 chars
    send_value(32'h8000_0000,  RADIX_HEX, '0);
    send_value(32'd9,          RADIX_DEC, '0);
    send_value(32'd10,         RADIX_DEC, '0);
    send_value(-32'd10,        RADIX_DEC, '0);
    send_value(32'd15,         RADIX_HEX, '0);
    send_value(32'd16,         RADIX_HEX, '0);
    send_value(32'd999999999,  RADIX_DEC, '0);
    send_value(32'd1000000000, RADIX_DEC, '0);
    send_value(32'hdead_beef,  RADIX_HEX, '0);
    send_value(32'hdead_beef,  RADIX_DEC, '0);
    send_value(32'h0abc_def0,  RADIX_HEX, '0);
    // fill bits above the fields must be ignored
    send_value(32'd12345,      RADIX_DEC, 7'h7f);
    send_value(32'h8000_0000,  RADIX_HEX, 7'h55);
    send_value(32'd0,          RADIX_DEC, 7'h2a);
  endtask

  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      send_value(pick_value(), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? 7'($urandom) : '0);
    end
  endtask

  // receiver holds off while the sender keeps offering; the block fills
  // its output register and has to drop s_tready
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs++;
    for (int i = 0; i < 20; i++) begin
      send_value(pick_value(), 1'($urandom_range(0, 1)), '0);
    end
  endtask

  // --- receiver ready ----------------------------------------------------
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --- result check: every output transfer against the oldest char -------
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_text.size() == 0) begin
        $error("unexpected out_char 0x%02h with no value pending", m_tdata);
        errors++;
      end else begin
        want = pending_text.pop_front();
        if (m_tdata !== want.ch) begin
          $error("out_char: expected 0x%02h, actual 0x%02h", want.ch, m_tdata);
          errors++;
        end
        if (m_tlast !== want.is_last) begin
          $error("last: expected %0b, actual %0b", want.is_last, m_tlast);
          errors++;
        end
      end
    end
  end

  // --- watchdog: too long without any transfer ---------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --- sequence ----------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(95, 0, 0);     // full rate
    test_random(95, 58, 0);    // sender idles
    test_random(95, 0, 58);    // receiver stalls
    test_random(95, 12, 12);   // both
    test_backpressure();

    s_tvalid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
